FILE: src/hsd_pkg.sv
// types, constants and parity-check matrix of the hsiao (72,64) secded decoder
// no dependencies
`timescale 1ns / 1ps

package hsd_pkg;

  localparam int CODE_BITS  = 72;
  localparam int CHECK_BITS = 8;
  localparam int DATA_BITS  = CODE_BITS - CHECK_BITS;
  localparam int POS_W      = $clog2(CODE_BITS + 1);

  localparam logic [POS_W-1:0] NO_FLIP = POS_W'(CODE_BITS);

  typedef enum logic [1:0] {
    ST_CORRECTED     = 2'd0,
    ST_SILENT        = 2'd1,
    ST_UNCORRECTABLE = 2'd2
  } status_e;

  // row r of the data part of h, bit c is the column of codeword position c + CHECK_BITS
  localparam logic [DATA_BITS-1:0] P_ROWS [CHECK_BITS] = '{
    64'h0738C808099264FF,
    64'h38C808099264FF07,
    64'hC808099264FF0738,
    64'h08099264FF0738C8,
    64'h099264FF0738C808,
    64'h9264FF0738C80809,
    64'h64FF0738C8080992,
    64'hFF0738C808099264
  };

  typedef struct packed {
    logic [CHECK_BITS-1:0] received_check;
    logic [DATA_BITS-1:0]  received_data;
  } in_t;

  typedef struct packed {
    logic [CHECK_BITS-1:0] corrected_check;
    logic [DATA_BITS-1:0]  corrected_data;
    logic [CHECK_BITS-1:0] syndrome;
    logic [POS_W-1:0]      flip_position;
    status_e               status;
  } out_t;

  // syndrome pattern of one codeword position
  function automatic logic [CHECK_BITS-1:0] column_of(input int pos);
    logic [CHECK_BITS-1:0] col;
    col = '0;
    if (pos < CHECK_BITS) begin
      col[pos] = 1'b1;
    end else begin
      for (int r = 0; r < CHECK_BITS; r++) begin
        col[r] = P_ROWS[r][pos - CHECK_BITS];
      end
    end
    return col;
  endfunction

endpackage

FILE: src/hsiao_secded_72_64_decoder_unit.sv
// top level of the hsiao (72,64) secded decoder: input register, decode logic, result register
// depends on hsd_pkg
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid_i / in_stall_o carry one received 72-bit word per transaction
//   (8 check bits and 64 data bits). Output channel: out_valid_o / out_stall_i carry the
//   corrected word, the syndrome, the flipped position and the status.
//   A transaction completes on a rising edge with valid high and stall low.
// Path: an accepted word is held in the input register until the result register can take it.
// Throughput: one word per cycle unless the receiver stalls; the syndrome, column match
//   and correction sit in one combinational stage between the input and result registers.
// Stall: while the result register holds a word that the receiver stalls, the input
//   register can still take one word if it is empty, then in_stall_o rises. Both registers
//   hold their contents and out_valid_o stays high until the word is taken.
// Reset: rst_ni clears both valid flags; no words are held and the data registers are not reset.
// Status codes: silent corruption for a zero syndrome, else uncorrectable when no column
//   matches, else corrected when the corrected word is all zero and silent corruption if not.
module hsiao_secded_72_64_decoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  hsd_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output hsd_pkg::out_t out_data_o
);
  import hsd_pkg::*;

  logic in_valid_q, in_valid_d;
  in_t  in_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;

  logic out_blocked;
  logic in_ready;
  logic in_accept;
  logic out_load;

  logic [CHECK_BITS-1:0] syn;
  logic [CODE_BITS-1:0]  word;
  logic [CODE_BITS-1:0]  match;
  logic [CODE_BITS-1:0]  first;
  logic [CODE_BITS-1:0]  fixed_word;
  logic [POS_W-1:0]      enc;
  logic                  any_match;
  out_t                  res;

  assign out_blocked = out_valid_q && out_stall_i;
  assign in_ready    = !in_valid_q || !out_blocked;
  assign in_stall_o  = !in_ready;
  assign in_accept   = in_valid_i && in_ready;
  assign out_load    = in_valid_q && !out_blocked;

  assign in_valid_d  = in_ready ? in_valid_i : in_valid_q;
  assign out_valid_d = out_blocked ? 1'b1 : in_valid_q;

  // syndrome
  always_comb begin
    for (int r = 0; r < CHECK_BITS; r++) begin
      syn[r] = in_q.received_check[r] ^ (^(in_q.received_data & P_ROWS[r]));
    end
  end

  // column match, lowest position wins
  assign word = {in_q.received_data, in_q.received_check};

  always_comb begin
    for (int p = 0; p < CODE_BITS; p++) begin
      match[p] = (column_of(p) == syn);
    end
  end

  assign first      = match & ~(match - CODE_BITS'(1));
  assign any_match  = |match;
  assign fixed_word = word ^ first;

  always_comb begin
    enc = '0;
    for (int p = 0; p < CODE_BITS; p++) begin
      enc = enc | (first[p] ? POS_W'(p) : '0);
    end
  end

  always_comb begin
    res.corrected_check = fixed_word[CHECK_BITS-1:0];
    res.corrected_data  = fixed_word[CODE_BITS-1:CHECK_BITS];
    res.syndrome        = syn;
    res.flip_position   = any_match ? enc : NO_FLIP;
    if (syn == '0) begin
      res.status = ST_SILENT;
    end else if (!any_match) begin
      res.status = ST_UNCORRECTABLE;
    end else if (fixed_word == '0) begin
      res.status = ST_CORRECTED;
    end else begin
      res.status = ST_SILENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_corrected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_CORRECTED |->
      out_q.corrected_check == '0 && out_q.corrected_data == '0)
    else $error("corrected status with nonzero word");

  a_zero_syndrome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.syndrome == '0 |->
      out_q.flip_position == NO_FLIP && out_q.status == ST_SILENT)
    else $error("zero syndrome not passed through");

  a_no_flip_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.flip_position == NO_FLIP && out_q.syndrome != '0 |->
      out_q.status == ST_UNCORRECTABLE)
    else $error("unmatched syndrome not flagged uncorrectable");

  a_flip_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.flip_position != NO_FLIP |->
      out_q.status != ST_UNCORRECTABLE && out_q.flip_position < NO_FLIP)
    else $error("flip reported with uncorrectable status");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_blocked |=> out_valid_q)
    else $error("decoded word lost between stages");

endmodule

FILE: test/hsiao_secded_72_64_decoder_unit_tb.sv
// testbench of the hsiao (72,64) secded decoder unit: directed and random received words,
// each result checked field by field against a decode computed here from the package matrix
// depends on hsd_pkg and hsiao_secded_72_64_decoder_unit
`timescale 1ns / 1ps

module hsiao_secded_72_64_decoder_unit_tb;

  import hsd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 10;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  in_t   in_data_i   = '0;
  logic  out_stall_i = 1'b0;
  logic  in_stall_o;
  logic  out_valid_o;
  out_t  out_data_o;

  out_t  decoded_q[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    hold_req    = 0;
  int    hold_ack    = 0;
  int    hold_left   = 0;

  hsiao_secded_72_64_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("hsiao_secded_72_64_decoder_unit_tb NOT OK");
      $finish;
    end
  end

  // syndrome, single-bit correction and status of one received word
  function automatic out_t decode_word(input in_t w);
    out_t                  r;
    logic [CHECK_BITS-1:0] syn;
    logic [CHECK_BITS-1:0] col;
    logic [CHECK_BITS-1:0] chk;
    logic [DATA_BITS-1:0]  dat;
    int                    flip;
    status_e               st;
    chk  = w.received_check;
    dat  = w.received_data;
    flip = CODE_BITS;
    for (int k = 0; k < CHECK_BITS; k++) begin
      syn[k] = chk[k] ^ (^(dat & P_ROWS[k]));
    end
    if (syn == '0) begin
      st = ST_SILENT;
    end else begin
      for (int p = 0; p < CODE_BITS; p++) begin
        for (int k = 0; k < CHECK_BITS; k++) begin
          col[k] = (p < CHECK_BITS) ? (p == k) : P_ROWS[k][p - CHECK_BITS];
        end
        if (flip == CODE_BITS && col == syn) begin
          flip = p;
        end
      end
      if (flip == CODE_BITS) begin
        st = ST_UNCORRECTABLE;
      end else begin
        if (flip < CHECK_BITS) begin
          chk[flip] = ~chk[flip];
        end else begin
          dat[flip - CHECK_BITS] = ~dat[flip - CHECK_BITS];
        end
        st = (chk == '0 && dat == '0) ? ST_CORRECTED : ST_SILENT;
      end
    end
    r.corrected_check = chk;
    r.corrected_data  = dat;
    r.syndrome        = syn;
    r.flip_position   = (flip == CODE_BITS) ? NO_FLIP : POS_W'(flip);
    r.status          = st;
    return r;
  endfunction

  // check bits that give a zero syndrome for this data
  function automatic in_t codeword(input logic [DATA_BITS-1:0] dat);
    in_t w;
    w.received_data = dat;
    for (int k = 0; k < CHECK_BITS; k++) begin
      w.received_check[k] = ^(dat & P_ROWS[k]);
    end
    return w;
  endfunction

  function automatic in_t flip_bit(input in_t w, input int pos);
    in_t r;
    r = w;
    if (pos < CHECK_BITS) begin
      r.received_check[pos] = ~r.received_check[pos];
    end else begin
      r.received_data[pos - CHECK_BITS] = ~r.received_data[pos - CHECK_BITS];
    end
    return r;
  endfunction

  function automatic logic [DATA_BITS-1:0] random_data();
    return {$urandom(), $urandom()};
  endfunction

  // mostly error patterns on the zero codeword, some on random codewords, some noise
  function automatic in_t random_word();
    in_t w;
    int  pick;
    int  p1;
    int  p2;
    pick = $urandom_range(99);
    p1   = $urandom_range(CODE_BITS - 1);
    p2   = (p1 + 1 + $urandom_range(CODE_BITS - 2)) % CODE_BITS;
    if (pick < 35) begin
      w = flip_bit('0, p1);
    end else if (pick < 55) begin
      w = flip_bit(flip_bit('0, p1), p2);
    end else if (pick < 65) begin
      w = flip_bit(flip_bit(flip_bit('0, p1), p2), $urandom_range(CODE_BITS - 1));
    end else if (pick < 80) begin
      w = codeword(random_data());
      if ($urandom_range(3) != 0) begin
        w = flip_bit(w, p1);
      end
    end else begin
      w.received_check = CHECK_BITS'($urandom());
      w.received_data  = random_data();
    end
    return w;
  endfunction

  // drive one transaction; valid stays high into the next call unless a gap is taken
  task automatic send_word(input in_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    decoded_q.push_back(decode_word(w));
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // receiver side: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("result with no transaction pending: %h", out_data_o);
        error_count++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (out_data_o.corrected_check !== exp_r.corrected_check) begin
          $error("corrected_check expected %h actual %h",
                 exp_r.corrected_check, out_data_o.corrected_check);
          error_count++;
        end
        if (out_data_o.corrected_data !== exp_r.corrected_data) begin
          $error("corrected_data expected %h actual %h",
                 exp_r.corrected_data, out_data_o.corrected_data);
          error_count++;
        end
        if (out_data_o.syndrome !== exp_r.syndrome) begin
          $error("syndrome expected %h actual %h", exp_r.syndrome, out_data_o.syndrome);
          error_count++;
        end
        if (out_data_o.flip_position !== exp_r.flip_position) begin
          $error("flip_position expected %0d actual %0d",
                 exp_r.flip_position, out_data_o.flip_position);
          error_count++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_data_o.status);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed_words();
    in_t ones;
    ones = '1;
    send_word('0);
    send_word(ones);
    send_word(flip_bit('0, 0));
    send_word(flip_bit('0, CHECK_BITS - 1));
    send_word(flip_bit('0, CHECK_BITS));
    send_word(flip_bit('0, 35));
    send_word(flip_bit('0, CODE_BITS - 1));
    send_word(flip_bit(flip_bit('0, 0), 1));
    send_word(flip_bit(flip_bit('0, CHECK_BITS), CODE_BITS - 1));
    send_word(flip_bit(flip_bit(flip_bit('0, 8), 9), 10));
    send_word(flip_bit(flip_bit(flip_bit('0, 0), 20), 50));
    send_word(codeword('1));
    send_word(flip_bit(codeword('1), 3));
    send_word(flip_bit(codeword('1), 40));
    send_word(codeword(64'hAAAA_AAAA_AAAA_AAAA));
    send_word(codeword(64'h5555_5555_5555_5555));
    send_word('{received_check: 8'hFF, received_data: '0});
    send_word('{received_check: 8'h00, received_data: '1});
    send_word('{received_check: 8'hA5, received_data: 64'h8000_0000_0000_0001});
    wait_drained();
  endtask

  task automatic test_random_words(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_word(random_word());
    wait_drained();
  endtask

  // long receiver hold-off while words keep coming, so the input side stalls
  task automatic test_output_hold();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= hold_req + 1;
    repeat (40) send_word(random_word());
    wait_drained();
  endtask

  // sender stops until every pending result is out, then resumes
  task automatic test_pause_until_drained();
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    repeat (25) send_word(random_word());
    wait_drained();
    repeat (25) send_word(random_word());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_words();
    test_random_words(29, 82, 550);
    test_random_words(82, 29, 550);
    test_random_words(0, 0, 550);
    test_output_hold();
    test_pause_until_drained();
    if (decoded_q.size() != 0) begin
      $error("%0d transactions never produced a result", decoded_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("hsiao_secded_72_64_decoder_unit_tb OK");
    end else begin
      $display("hsiao_secded_72_64_decoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
